FILE: hw/rtl/brs_pkg.sv
`default_nettype none
package brs_pkg;

	localparam int MAX_BLOCK_BYTES = 65536;
	localparam int BL_W = $clog2(MAX_BLOCK_BYTES + 1);
	localparam int LEN_W = 17;
	localparam int CMP_W = (BL_W > LEN_W) ? BL_W : LEN_W;
	localparam int CNT_W = 17;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ARENA_CAPACITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LIMIT = CFG_IDX_W'(1);
	localparam logic [31:0] ARENA_CAPACITY_RST = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0] RECORD_LIMIT_RST = CNT_W'(65536);

	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 280;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// byte positions inside a record, counted from the first size byte
	localparam int SIZE_LAST = 3;
	localparam int ID_FIRST = 4;
	localparam int POS_FIRST = 8;
	localparam int POS_END = 12;
	localparam int FLAG_LO = 18;
	localparam int FLAG_HI = 19;
	localparam int HDR_BYTES = 4;
	localparam int MIN_SIZE = 32;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT_HDR   = 3'd1,
		ST_TOO_SMALL   = 3'd2,
		ST_TRUNCATED   = 3'd3,
		ST_ARENA_FULL  = 3'd4,
		ST_TOO_MANY    = 3'd5
	} status_t;

	// one result as handed from the parser to the output side;
	// arena offset is still split into base and bytes used
	typedef struct packed {
		logic          kind;
		logic [31:0]   reference_id;
		logic [31:0]   position;
		logic [15:0]   flag_bits;
		logic [16:0]   record_length;
		logic [31:0]   arena_used;
		logic [63:0]   arena_base;
		logic [31:0]   order_block;
		logic [16:0]   record_number;
		status_t       status_code;
		logic [32:0]   fault_amount;
		logic [31:0]   fault_bound;
	} event_t;

endpackage
`default_nettype wire

FILE: hw/rtl/brs_front.sv
`default_nettype none
module brs_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [brs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [brs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	input  wire logic [7:0]                        data_byte,
	input  wire logic                              block_start,
	input  wire logic [brs_pkg::LEN_W-1:0]         block_length,
	input  wire logic [31:0]                       block_number,
	input  wire logic [63:0]                       arena_base,
	output logic                                   ev_valid,
	output brs_pkg::event_t                        ev
);
	import brs_pkg::*;

	logic [31:0]      arena_cap_q;
	logic [CNT_W-1:0] rec_limit_q;

	logic [BL_W-1:0]  bytes_left_q;
	logic [BL_W-1:0]  rbi_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      used_q;
	logic             skip_q;
	logic [31:0]      size_q;
	logic [31:0]      id_q;
	logic [31:0]      pos_q;
	logic [7:0]       flag_lo_q;
	logic [31:0]      block_q;
	logic [63:0]      base_q;

	logic [CMP_W-1:0] len_ext;
	logic [BL_W-1:0]  len_clamp;
	logic             start_empty;
	logic             active;
	logic [BL_W-1:0]  bl_e;
	logic [BL_W-1:0]  rbi_e;
	logic [CNT_W-1:0] count_e;
	logic [31:0]      used_e;
	logic [31:0]      block_e;
	logic [63:0]      base_e;
	logic [31:0]      size_d;
	logic [32:0]      raw_len;
	logic [32:0]      remain;
	logic [31:0]      room;
	logic             cap_lt;
	logic             at_size_last;
	logic             fail;
	status_t          fail_code;
	logic [32:0]      fail_actual;
	logic [31:0]      fail_limit;
	logic             rec_emit;
	logic [BL_W-1:0]  bl_dec;
	logic             end_blk;
	logic [BL_W-1:0]  rbi_next;
	logic             step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_cap_q <= ARENA_CAPACITY_RST;
			rec_limit_q <= RECORD_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ARENA_CAPACITY: arena_cap_q <= cfg_data[31:0];
				CFG_RECORD_LIMIT:   rec_limit_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		len_ext = CMP_W'(block_length);
		if (len_ext > CMP_W'(MAX_BLOCK_BYTES))
			len_clamp = BL_W'(MAX_BLOCK_BYTES);
		else
			len_clamp = BL_W'(len_ext);
	end

	assign start_empty = block_start && (len_clamp == '0);
	assign active      = block_start ? !start_empty : !skip_q;
	assign bl_e        = block_start ? len_clamp : bytes_left_q;
	assign rbi_e       = block_start ? '0 : rbi_q;
	assign count_e     = block_start ? '0 : count_q;
	assign used_e      = block_start ? '0 : used_q;
	assign block_e     = block_start ? block_number : block_q;
	assign base_e      = block_start ? arena_base : base_q;

	// assemble the little-endian size word
	always_comb begin
		size_d = size_q;
		if (rbi_e == '0)
			size_d = {24'b0, data_byte};
		else if (rbi_e < BL_W'(HDR_BYTES))
			size_d[{rbi_e[1:0], 3'b000} +: 8] = data_byte;
	end

	assign raw_len      = {1'b0, size_d} + 33'(HDR_BYTES);
	assign remain       = 33'(bl_e) + 33'(SIZE_LAST);
	assign room         = arena_cap_q - used_e;
	assign cap_lt       = arena_cap_q < used_e;
	assign at_size_last = rbi_e == BL_W'(SIZE_LAST);

	// header checks, in priority order
	always_comb begin
		fail        = 1'b0;
		fail_code   = ST_OK;
		fail_actual = '0;
		fail_limit  = '0;
		priority if (rbi_e == '0 && bl_e < BL_W'(HDR_BYTES)) begin
			fail        = 1'b1;
			fail_code   = ST_SHORT_HDR;
			fail_actual = 33'(bl_e);
			fail_limit  = 32'(HDR_BYTES);
		end else if (at_size_last && size_d < 32'(MIN_SIZE)) begin
			fail      = 1'b1;
			fail_code = ST_TOO_SMALL;
		end else if (at_size_last && raw_len > remain) begin
			fail        = 1'b1;
			fail_code   = ST_TRUNCATED;
			fail_actual = raw_len;
			fail_limit  = remain[31:0];
		end else if (at_size_last && (cap_lt || raw_len > {1'b0, room})) begin
			fail        = 1'b1;
			fail_code   = ST_ARENA_FULL;
			fail_actual = raw_len;
			fail_limit  = cap_lt ? '0 : room;
		end else if (at_size_last && count_e >= rec_limit_q) begin
			fail        = 1'b1;
			fail_code   = ST_TOO_MANY;
			fail_actual = 33'(count_e) + 33'd1;
			fail_limit  = 32'(rec_limit_q);
		end else begin
			fail = 1'b0;
		end
	end

	assign rec_emit = active && !fail && rbi_e == BL_W'(FLAG_HI);
	assign bl_dec   = bl_e - BL_W'(1);
	assign end_blk  = active && !fail && bl_dec == '0;

	always_comb begin
		if (33'(rbi_e) + 33'd1 >= raw_len && rbi_e >= BL_W'(SIZE_LAST))
			rbi_next = '0;
		else
			rbi_next = rbi_e + BL_W'(1);
	end

	always_comb begin
		ev               = '0;
		ev.order_block   = block_e;
		ev.record_number = count_e;
		ev.status_code   = ST_OK;
		if (start_empty) begin
			ev.kind = KIND_SUMMARY;
		end else if (fail) begin
			ev.kind         = KIND_SUMMARY;
			ev.status_code  = fail_code;
			ev.fault_amount = fail_actual;
			ev.fault_bound  = fail_limit;
		end else if (rec_emit) begin
			ev.kind          = KIND_RECORD;
			ev.reference_id  = id_q;
			ev.position      = pos_q;
			ev.flag_bits     = {data_byte, flag_lo_q};
			ev.record_length = raw_len[16:0];
			ev.arena_used    = used_e;
			ev.arena_base    = base_e;
		end else begin
			ev.kind = KIND_SUMMARY;
		end
	end

	assign ev_valid = in_valid && (start_empty || (active && (fail || rec_emit || end_blk)));
	assign step     = in_valid && (block_start || !skip_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			rbi_q        <= '0;
			count_q      <= '0;
			used_q       <= '0;
			skip_q       <= 1'b1;
		end else if (step) begin
			count_q <= count_e;
			used_q  <= used_e;
			if (start_empty || fail) begin
				rbi_q  <= rbi_e;
				skip_q <= 1'b1;
			end else begin
				rbi_q        <= rbi_next;
				bytes_left_q <= bl_dec;
				skip_q       <= bl_dec == '0;
				if (rec_emit) begin
					count_q <= count_e + CNT_W'(1);
					used_q  <= used_e + raw_len[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			block_q <= block_e;
			base_q  <= base_e;
			if (!start_empty && !fail) begin
				size_q <= size_d;
				if (rbi_e >= BL_W'(ID_FIRST) && rbi_e < BL_W'(POS_FIRST))
					id_q[{rbi_e[1:0], 3'b000} +: 8] <= data_byte;
				if (rbi_e >= BL_W'(POS_FIRST) && rbi_e < BL_W'(POS_END))
					pos_q[{rbi_e[1:0], 3'b000} +: 8] <= data_byte;
				if (rbi_e == BL_W'(FLAG_LO))
					flag_lo_q <= data_byte;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/brs_queue.sv
`default_nettype none
module brs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire brs_pkg::event_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output logic                 valid,
	output brs_pkg::event_t      data
);
	import brs_pkg::*;

	event_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign valid   = cnt_q != '0;
	assign data    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/brs_back.sv
`default_nettype none
module brs_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire brs_pkg::event_t               q_data,
	output logic                               pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [brs_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                               m_tuser
);
	import brs_pkg::*;

	logic                 valid_q;
	logic [M_TDATA_W-1:0] data_q;
	logic                 kind_q;
	logic [63:0]          arena_offset;

	assign pop          = q_valid && (!valid_q || m_tready);
	// base and used are both zero in a summary
	assign arena_offset = q_data.arena_base + {32'b0, q_data.arena_used};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= q_data.kind;
			data_q <= {2'b0,
			           q_data.fault_bound,
			           q_data.fault_amount,
			           q_data.status_code,
			           q_data.record_number,
			           q_data.order_block,
			           arena_offset,
			           q_data.record_length,
			           q_data.flag_bits,
			           q_data.position,
			           q_data.reference_id};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;

endmodule
`default_nettype wire

FILE: hw/rtl/bam_record_splitter_core.sv
// Alignment record splitter.
// s_* stream: one byte of a decompressed block per transaction. s_tuser is the
// block start flag; on that transaction length, block number and arena base
// are taken from s_tdata as well. A block length of zero carries no byte.
// m_* stream: per good record one metadata transaction once body byte 15 is
// in; per block one summary (m_tuser=1) at its last byte or first bad header.
// A block restarted mid-way is dropped without a summary.
// cfg_we/cfg_index/cfg_data write arena capacity (0) and record limit (1);
// write them only while no block is in flight.
// Throughput: one byte per cycle while the queue has space. The edge that
// accepts a byte pushes its result into a four-entry queue; the output
// register pops it and adds the arena offset.
// When m_tready stays low the queue fills and s_tready falls once it holds
// four results; bytes that produce no result also wait for that space.
// Reset: configuration returns to all ones and 65536, the parser idles until
// a block start, queue and output register empty.
`default_nettype none
module bam_record_splitter_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [brs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [brs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// data_byte, block_length, block_number, arena_base, zero pad
	input  wire logic [brs_pkg::S_TDATA_W-1:0]    s_tdata,
	// block_start
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// reference_id, position, flag_bits, record_length, arena_offset,
	// order_block, record_number, status_code, fault amount, fault bound, pad
	output logic [brs_pkg::M_TDATA_W-1:0]         m_tdata,
	// result_kind
	output logic                                  m_tuser
);
	import brs_pkg::*;

	logic   accept;
	logic   ev_valid;
	event_t ev;
	logic   q_full;
	logic   q_valid;
	event_t q_data;
	logic   q_pop;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	brs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (accept),
		.data_byte    (s_tdata[7:0]),
		.block_start  (s_tuser),
		.block_length (s_tdata[24:8]),
		.block_number (s_tdata[56:25]),
		.arena_base   (s_tdata[120:57]),
		.ev_valid     (ev_valid),
		.ev           (ev)
	);

	brs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_valid),
		.push_data (ev),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.data      (q_data)
	);

	brs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
module tb;
	import brs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        start;
		logic [63:0] base;
		logic [31:0] bnum;
		logic [16:0] blen;
		logic [7:0]  dbyte;
	} byte_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] rid;
		logic [31:0] pos;
		logic [15:0] flags;
		logic [16:0] rlen;
		logic [63:0] aoff;
		logic [31:0] oblk;
		logic [16:0] rnum;
		status_t     status;
		logic [32:0] actual;
		logic [31:0] lim;
	} split_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// data_byte, block_length, block_number, arena_base, zero pad
	logic [S_TDATA_W-1:0] s_tdata = '0;
	// block_start
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// reference_id, position, flag_bits, record_length, arena_offset,
	// order_block, record_number, status_code, fault amount, fault bound, pad
	logic [M_TDATA_W-1:0] m_tdata;
	// result_kind
	logic m_tuser;

	bam_record_splitter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	byte_item_t byte_feed [$];
	byte_item_t in_flight;
	split_result_t due_results [$];
	logic [7:0] blk_bytes [$];

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int bytes_sent = 0;
	int records_seen = 0;
	int status_hits [8];
	int unsigned cycle_count = 0;
	int ph, n, batch;

	// splitter state as the block should hold it
	logic [31:0] cap_reg = ARENA_CAPACITY_RST;
	logic [16:0] lim_reg = RECORD_LIMIT_RST;
	logic [16:0] left = '0;
	logic [16:0] idx = '0;
	logic [31:0] size_w = '0;
	logic [31:0] id_w = '0;
	logic [31:0] pos_w = '0;
	logic [15:0] flag_h = '0;
	logic [16:0] count = '0;
	logic [31:0] used = '0;
	logic [31:0] blk_no = '0;
	logic [63:0] base = '0;
	logic idle = 1'b1;

	task automatic push_summary(input status_t st, input logic [32:0] act, input logic [31:0] lim);
		split_result_t r;
		r = '0;
		r.kind = KIND_SUMMARY;
		r.oblk = blk_no;
		r.rnum = count;
		r.status = st;
		r.actual = act;
		r.lim = lim;
		due_results.push_back(r);
		idle = 1'b1;
	endtask

	task automatic parse_byte(input byte_item_t it);
		logic [16:0] len;
		logic [32:0] need;
		logic [32:0] avail;
		logic [31:0] room;
		split_result_t r;
		bit made;
		made = 1'b0;
		if (it.start) begin
			len = (it.blen > 17'(MAX_BLOCK_BYTES)) ? 17'(MAX_BLOCK_BYTES) : it.blen;
			blk_no = it.bnum;
			base = it.base;
			used = '0;
			count = '0;
			idx = '0;
			size_w = '0;
			idle = 1'b0;
			if (len == 0) begin
				push_summary(ST_OK, '0, '0);
				return;
			end
			left = len;
		end else if (idle) begin
			return;
		end

		if (idx == 0) begin
			if (left < HDR_BYTES) begin
				push_summary(ST_SHORT_HDR, {16'd0, left}, HDR_BYTES);
				return;
			end
			size_w = {24'd0, it.dbyte};
		end else if (idx <= SIZE_LAST) begin
			size_w[8*idx +: 8] = it.dbyte;
			if (idx == SIZE_LAST) begin
				need = {1'b0, size_w} + 33'd4;
				avail = {16'd0, left} + 33'd3;
				room = cap_reg - used;
				if (size_w < MIN_SIZE) begin
					push_summary(ST_TOO_SMALL, '0, '0);
					return;
				end
				if (need > avail) begin
					push_summary(ST_TRUNCATED, need, avail[31:0]);
					return;
				end
				if (cap_reg < used || need > {1'b0, room}) begin
					push_summary(ST_ARENA_FULL, need, (cap_reg < used) ? 32'd0 : room);
					return;
				end
				if (count >= lim_reg) begin
					push_summary(ST_TOO_MANY, {16'd0, count} + 33'd1, {15'd0, lim_reg});
					return;
				end
			end
		end else if (idx < POS_FIRST) begin
			id_w[8*(idx-ID_FIRST) +: 8] = it.dbyte;
		end else if (idx < POS_END) begin
			pos_w[8*(idx-POS_FIRST) +: 8] = it.dbyte;
		end else if (idx == FLAG_LO) begin
			flag_h = {8'd0, it.dbyte};
		end else if (idx == FLAG_HI) begin
			flag_h[15:8] = it.dbyte;
			need = {1'b0, size_w} + 33'd4;
			r = '0;
			r.kind = KIND_RECORD;
			r.rid = id_w;
			r.pos = pos_w;
			r.flags = flag_h;
			r.rlen = need[16:0];
			r.aoff = base + {32'd0, used};
			r.oblk = blk_no;
			r.rnum = count;
			r.status = ST_OK;
			due_results.push_back(r);
			made = 1'b1;
			used = used + need[31:0];
			count = count + 17'd1;
		end

		// wrap to the next header after the last body byte
		if (({16'd0, idx} + 33'd1 >= {1'b0, size_w} + 33'd4) && idx >= SIZE_LAST)
			idx = '0;
		else
			idx = idx + 17'd1;

		left = left - 17'd1;
		if (left == 0) begin
			idle = 1'b1;
			if (!made)
				push_summary(ST_OK, '0, '0);
		end
	endtask

	function automatic byte_item_t noise_item();
		byte_item_t it;
		it.start = 1'b0;
		it.base = {$urandom, $urandom};
		it.bnum = $urandom;
		it.blen = 17'($urandom);
		it.dbyte = 8'($urandom);
		return it;
	endfunction

	task automatic add_record(input logic [31:0] size, input logic [31:0] rid,
			input logic [31:0] rpos, input logic [15:0] flg, input int body_n);
		int k;
		for (k = 0; k < 4; k++)
			blk_bytes.push_back(size[8*k +: 8]);
		for (k = 0; k < body_n; k++) begin
			if (k < 4)
				blk_bytes.push_back(rid[8*k +: 8]);
			else if (k < 8)
				blk_bytes.push_back(rpos[8*(k-4) +: 8]);
			else if (k == 14)
				blk_bytes.push_back(flg[7:0]);
			else if (k == 15)
				blk_bytes.push_back(flg[15:8]);
			else
				blk_bytes.push_back(8'($urandom));
		end
	endtask

	// queue a block header transaction, which carries the first byte, and at most nsend bytes of blk_bytes in all
	task automatic emit_block(input logic [16:0] len, input logic [31:0] bnum,
			input logic [63:0] abase, input int nsend);
		byte_item_t it;
		int i;
		it.start = 1'b1;
		it.blen = len;
		it.bnum = bnum;
		it.base = abase;
		it.dbyte = (blk_bytes.size() > 0) ? blk_bytes[0] : 8'($urandom);
		byte_feed.push_back(it);
		for (i = 1; i < nsend && i < blk_bytes.size(); i++) begin
			it = noise_item();
			it.dbyte = blk_bytes[i];
			byte_feed.push_back(it);
		end
		blk_bytes.delete();
	endtask

	task automatic push_noise(input int cnt);
		int i;
		for (i = 0; i < cnt; i++)
			byte_feed.push_back(noise_item());
	endtask

	task automatic gen_block(output int added);
		int feed_mark, nrec, v, i, sz, total;
		logic [31:0] bnum;
		logic [63:0] abase;
		feed_mark = byte_feed.size();
		bnum = $urandom;
		abase = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			abase = {32'hFFFF_FFFF, 24'hFF_FFFF, 8'($urandom)};
		v = $urandom_range(0, 99);
		if (v < 5) begin
			emit_block('0, bnum, abase, 0);
		end else begin
			nrec = $urandom_range(1, 3);
			for (i = 0; i < nrec; i++) begin
				sz = ($urandom_range(0, 9) == 0) ? $urandom_range(73, 300) : $urandom_range(32, 72);
				add_record(sz, $urandom, $urandom, 16'($urandom), sz);
			end
			if (v < 60) begin
				total = blk_bytes.size();
			end else if (v < 70) begin
				// short header tail
				sz = $urandom_range(1, 3);
				for (i = 0; i < sz; i++)
					blk_bytes.push_back(8'($urandom));
				total = blk_bytes.size();
			end else if (v < 78) begin
				add_record($urandom_range(0, MIN_SIZE - 1), $urandom, $urandom, 16'($urandom),
					$urandom_range(0, 8));
				total = blk_bytes.size();
			end else if (v < 86) begin
				total = blk_bytes.size() - $urandom_range(1, 16);
			end else if (v < 92) begin
				add_record({1'b1, 31'($urandom)}, 0, 0, 0, 0);
				total = blk_bytes.size();
			end else begin
				// abandon part way; the next block start restarts the parser
				total = blk_bytes.size();
				emit_block(17'(total), bnum, abase, $urandom_range(1, total - 1));
				added = byte_feed.size() - feed_mark;
				return;
			end
			emit_block(17'(total), bnum, abase, total);
		end
		if ($urandom_range(0, 9) == 0)
			push_noise($urandom_range(1, 3));
		added = byte_feed.size() - feed_mark;
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (ri == CFG_ARENA_CAPACITY)
			cap_reg = val;
		else if (ri == CFG_RECORD_LIMIT)
			lim_reg = val[16:0];
	endtask

	// hold off until every queued byte went in and every result came out
	task settle();
		do @(negedge clk);
		while (byte_feed.size() != 0 || s_tvalid || due_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_result();
		split_result_t want;
		if (due_results.size() == 0) begin
			report_mismatch("result transaction with nothing pending");
			return;
		end
		want = due_results.pop_front();
		cmp_field("result_kind", m_tuser, want.kind);
		cmp_field("reference_id", m_tdata[31:0], want.rid);
		cmp_field("position", m_tdata[63:32], want.pos);
		cmp_field("flag_bits", m_tdata[79:64], want.flags);
		cmp_field("record_length", m_tdata[96:80], want.rlen);
		cmp_field("arena_offset", m_tdata[160:97], want.aoff);
		cmp_field("order_block", m_tdata[192:161], want.oblk);
		cmp_field("record_number", m_tdata[209:193], want.rnum);
		cmp_field("status_code", m_tdata[212:210], want.status);
		cmp_field("fault amount", m_tdata[245:213], want.actual);
		cmp_field("fault bound", m_tdata[277:246], want.lim);
		if (want.kind == KIND_RECORD)
			records_seen++;
		else
			status_hits[want.status]++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_byte(in_flight);
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					in_flight = byte_feed.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, in_flight.base, in_flight.bnum, in_flight.blen,
						in_flight.dbyte};
					s_tuser <= in_flight.start;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && m_tvalid && m_tready)
			check_result();
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		foreach (status_hits[i])
			status_hits[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks at reset configuration
		push_noise(1);
		emit_block('0, 32'hFFFF_FFFF, 64'd0, 0);
		add_record(32, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 32);
		add_record(40, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 40);
		emit_block(17'd76, 32'd0, 64'hFFFF_FFFF_FFFF_FFEC, 76);
		push_noise(2);
		add_record(32, $urandom, $urandom, 16'($urandom), 32);
		blk_bytes.push_back(8'h5A);
		blk_bytes.push_back(8'hA5);
		blk_bytes.push_back(8'h00);
		emit_block(17'd39, $urandom, {$urandom, $urandom}, 39);
		blk_bytes.push_back(8'hFF);
		blk_bytes.push_back(8'h00);
		emit_block(17'd2, $urandom, {$urandom, $urandom}, 2);
		add_record(MIN_SIZE - 1, $urandom, $urandom, 16'($urandom), 31);
		emit_block(17'd35, $urandom, {$urandom, $urandom}, 35);
		add_record(40, $urandom, $urandom, 16'($urandom), 36);
		emit_block(17'd40, $urandom, {$urandom, $urandom}, 40);
		// oversized lengths get clamped; huge size words overflow 32 bits
		add_record(32'hFFFF_FFFF, 0, 0, 0, 2);
		emit_block(17'd100000, $urandom, {$urandom, $urandom}, 6);
		add_record(32'h0001_FFFF, 0, 0, 0, 1);
		emit_block(17'h1FFFF, $urandom, {$urandom, $urandom}, 5);
		add_record(32'd16, 0, 0, 0, 0);
		emit_block(17'd65536, $urandom, {$urandom, $urandom}, 4);
		// restart a block right after its metadata went out
		add_record(48, $urandom, $urandom, 16'($urandom), 48);
		emit_block(17'd52, $urandom, {$urandom, $urandom}, 20);
		emit_block('0, $urandom, {$urandom, $urandom}, 0);
		settle();

		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_gap_pct = 0; recv_stall_pct = 0; end
				1: begin send_gap_pct = 73; recv_stall_pct = 0; end
				2: begin send_gap_pct = 0; recv_stall_pct = 73; end
				default: begin send_gap_pct = 15; recv_stall_pct = 15; end
			endcase
			case (ph)
				1: begin
					write_reg(CFG_ARENA_CAPACITY, $urandom_range(80, 400));
					write_reg(CFG_RECORD_LIMIT, $urandom_range(1, 4));
				end
				2: begin
					write_reg(CFG_ARENA_CAPACITY, 32'hFFFF_FFFF);
					write_reg(CFG_RECORD_LIMIT, 32'd65536);
				end
				3: begin
					write_reg(CFG_ARENA_CAPACITY, 32'd0);
					write_reg(CFG_RECORD_LIMIT, 32'd0);
				end
				4: begin
					write_reg(CFG_ARENA_CAPACITY, 32'hFFFF_FFFF);
					write_reg(CFG_RECORD_LIMIT, 32'd0);
				end
				5: begin
					write_reg(CFG_ARENA_CAPACITY, $urandom_range(36, 200));
					write_reg(CFG_RECORD_LIMIT, 32'd65536);
				end
				6: begin
					write_reg(CFG_ARENA_CAPACITY, 32'hFFFF_FFFF);
					write_reg(CFG_RECORD_LIMIT, $urandom_range(1, 3));
				end
				7: begin
					write_reg(CFG_ARENA_CAPACITY, $urandom);
					write_reg(CFG_RECORD_LIMIT, $urandom_range(0, 65536));
				end
				default: ;
			endcase
			batch = 0;
			while (batch < 130) begin
				gen_block(n);
				batch += n;
			end
			// close any abandoned block so the parser is idle for the next write
			emit_block('0, $urandom, {$urandom, $urandom}, 0);
			settle();
		end

		$display("Sent %0d byte transactions over 8 config/idle phases; %0d record results",
			bytes_sent, records_seen);
		$display("Block summaries ok/short/small/truncated/arena/limit: %0d %0d %0d %0d %0d %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			status_hits[4], status_hits[5]);
		if (errors == 0 && due_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/brs_pkg.sv
hw/rtl/brs_front.sv
hw/rtl/brs_queue.sv
hw/rtl/brs_back.sv
hw/rtl/bam_record_splitter_core.sv
sim/tb.sv
